// ===== rtl/hdtff_pkg.sv =====
// shared constants and types for the header typed frame finder
package hdtff_pkg;

	localparam int STORE_DEPTH = 16;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int CNT_RAW_W   = $clog2(STORE_DEPTH + 1);
	localparam int CNT_W       = (CNT_RAW_W > 5) ? CNT_RAW_W : 5;

	localparam logic [7:0] HDR_FIRST  = 8'h13;
	localparam logic [7:0] HDR_SECOND = 8'h14;
	localparam logic [7:0] TYPE_SHORT = 8'd6;
	localparam logic [7:0] TYPE_LONG  = 8'd8;
	localparam logic [3:0] LEN_SHORT  = 4'd9;
	localparam logic [3:0] LEN_LONG   = 4'd11;
	localparam logic [4:0] LIMIT_MIN  = 5'd3;
	localparam logic [4:0] LIMIT_RST  = 5'd16;
	localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(STORE_DEPTH);

	typedef struct packed {
		logic             load;
		logic             shift;
		logic [IDX_W-1:0] wr_idx;
		logic [7:0]       data;
	} cell_ctl_t;

endpackage

// ===== rtl/header_typed_frame_finder.sv =====
// top level: header hunt, frame fill control and frame emission
//
// Input channel rx_valid / rx_stall / rx_byte takes one received byte per
// transaction. Bytes other than 0x13 are dropped while hunting; 0x13 must be
// followed by 0x14. Header and following bytes go into a row of byte cells.
// Byte 2 is the type: type 6 completes at 9 bytes, type 8 at 11 bytes.
// A frame that reaches the limit in cfg_wr_data (saturated to 3..STORE_DEPTH)
// without completing is dropped and the hunt restarts.
// Input transactions are accepted only while no frame is being emitted.
// On completion the output channel frame_valid / frame_stall presents the
// frame one byte per cycle, header first, with byte_index, frame_length and
// last_of_frame; the first byte is valid the cycle after the completing byte.
// The cell row shifts one place toward cell 0 per output transaction, so a
// frame holds rx_stall high until its last byte has been taken; a stall on
// the output side holds the current byte and keeps rx_stall high longer.
// Reset clears the hunt state, the emission state and sets the limit to 16.
module header_typed_frame_finder
	import hdtff_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [4:0] cfg_wr_data,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       frame_valid,
	input  logic       frame_stall,
	output logic [7:0] frame_byte,
	output logic [3:0] byte_index,
	output logic [3:0] frame_length,
	output logic       last_of_frame
);

	logic [4:0]       limit_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       type_q;
	logic             emit_q;
	logic [3:0]       idx_q;
	logic [3:0]       len_q;

	logic [CNT_W-1:0] limit_ext;
	logic [CNT_W-1:0] lim;
	logic             rx_take;
	logic             out_take;
	logic             do_store;
	logic             clear_cnt;
	logic [CNT_W-1:0] next_cnt;
	logic [7:0]       type_cur;
	logic [3:0]       done_len;
	cell_ctl_t        ctl;
	logic [7:0]       cell_data [STORE_DEPTH];

	assign limit_ext = CNT_W'(limit_q);
	always_comb begin
		if (limit_q < LIMIT_MIN) begin
			lim = CNT_W'(LIMIT_MIN);
		end else if (limit_ext > LIMIT_MAX) begin
			lim = LIMIT_MAX;
		end else begin
			lim = limit_ext;
		end
	end

	assign rx_stall = emit_q;
	assign rx_take  = rx_valid && !rx_stall;
	assign out_take = frame_valid && !frame_stall;

	always_comb begin
		do_store  = 1'b0;
		clear_cnt = 1'b0;
		done_len  = 4'd0;
		next_cnt  = count_q + CNT_W'(1);
		type_cur  = (count_q == CNT_W'(2)) ? rx_byte : type_q;
		if (count_q == '0) begin
			do_store = (rx_byte == HDR_FIRST);
		end else if (count_q == CNT_W'(1)) begin
			do_store  = (rx_byte == HDR_SECOND);
			clear_cnt = (rx_byte != HDR_SECOND);
		end else begin
			do_store = 1'b1;
		end
		// limit lowered under a partial frame: drop it
		if (do_store && (count_q >= lim)) begin
			do_store  = 1'b0;
			clear_cnt = 1'b1;
		end
		if (do_store && (next_cnt >= CNT_W'(3))) begin
			if ((type_cur == TYPE_SHORT) && (next_cnt == CNT_W'(LEN_SHORT))) begin
				done_len = LEN_SHORT;
			end else if ((type_cur == TYPE_LONG) && (next_cnt == CNT_W'(LEN_LONG))) begin
				done_len = LEN_LONG;
			end
		end
	end

	assign ctl.load   = rx_take && do_store;
	assign ctl.shift  = out_take;
	assign ctl.wr_idx = count_q[IDX_W-1:0];
	assign ctl.data   = rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			emit_q  <= 1'b0;
			idx_q   <= 4'd0;
		end else begin
			if (rx_take) begin
				if (clear_cnt || (do_store && (done_len != 4'd0))) begin
					count_q <= '0;
				end else if (do_store) begin
					count_q <= (next_cnt >= lim) ? '0 : next_cnt;
				end
				if (do_store && (done_len != 4'd0)) begin
					emit_q <= 1'b1;
					idx_q  <= 4'd0;
				end
			end
			if (out_take) begin
				if (last_of_frame) begin
					emit_q <= 1'b0;
				end
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take && do_store && (count_q == CNT_W'(2))) begin
			type_q <= rx_byte;
		end
		if (rx_take && do_store && (done_len != 4'd0)) begin
			len_q <= done_len;
		end
	end

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		logic [7:0] nbr;
		if (i == STORE_DEPTH - 1) begin : g_end
			assign nbr = 8'h00;
		end else begin : g_mid
			assign nbr = cell_data[i+1];
		end
		hdtff_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.my_idx   (IDX_W'(i)),
			.nbr_data (nbr),
			.data_q   (cell_data[i])
		);
	end

	assign frame_valid   = emit_q;
	assign frame_byte    = cell_data[0];
	assign byte_index    = idx_q;
	assign frame_length  = len_q;
	assign last_of_frame = (idx_q == (len_q - 4'd1));

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && last_of_frame |=> !frame_valid)
		else $error("frame_valid held after last byte");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !last_of_frame |=>
			frame_valid && (byte_index == 4'($past(byte_index) + 4'd1)))
		else $error("byte_index did not advance");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> byte_index < frame_length)
		else $error("byte_index beyond frame_length");

	a_header_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(frame_valid) |-> (byte_index == 4'd0) && (frame_byte == HDR_FIRST))
		else $error("frame does not start with header");

	a_hunt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> count_q == '0)
		else $error("fill count nonzero while emitting");

endmodule

// ===== rtl/hdtff_cell.sv =====
// one byte cell of the frame store chain
module hdtff_cell
	import hdtff_pkg::*;
(
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [IDX_W-1:0] my_idx,
	input  logic [7:0]       nbr_data,
	output logic [7:0]       data_q
);

	// shift toward cell 0 while emitting, capture own slot while filling
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= nbr_data;
		end else if (ctl.load && (ctl.wr_idx == my_idx)) begin
			data_q <= ctl.data;
		end
	end

endmodule
